FILE: rtl/gsmv_pkg.sv
// ----------------------------------------------------------------------------
// gsmv_pkg
// shared types and constants for the four-point stencil matrix-vector block
// ----------------------------------------------------------------------------
package gsmv_pkg;

    localparam int VALUE_W    = 32;
    localparam int COEF_W     = 18;
    localparam int FRAC_W     = 16;
    localparam int CFG_W      = 7;
    localparam int GRID_RESET = 64;
    localparam int PROD_W     = VALUE_W + COEF_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int QDEPTH     = 4;
    localparam int QPW        = $clog2(QDEPTH);
    localparam int QLW        = $clog2(QDEPTH + 1);

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [0:0] {
        OP_DATA  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    typedef struct packed {
        coef_t west;
        coef_t east;
        coef_t north;
        coef_t south;
    } coef_set_t;

    // one point's work: neighbours already masked to zero off the grid
    typedef struct packed {
        value_t    west;
        value_t    east;
        value_t    north;
        value_t    south;
        coef_set_t coef;
        logic      last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic           not_empty;
        logic [QLW-1:0] level;
    } queue_status_t;

endpackage

FILE: rtl/gsmv_front.sv
// ----------------------------------------------------------------------------
// gsmv_front
// accepts words, keeps the line buffers and issues one job per result point
// ----------------------------------------------------------------------------
module gsmv_front #(
    parameter int MAX_GRID = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gsmv_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              op,
    input  gsmv_pkg::value_t                  point_value,
    input  gsmv_pkg::coef_t                   coef_west,
    input  gsmv_pkg::coef_t                   coef_east,
    input  gsmv_pkg::coef_t                   coef_north,
    input  gsmv_pkg::coef_t                   coef_south,
    input  gsmv_pkg::queue_status_t           q_status,
    output gsmv_pkg::job_push_t               job_push
);

    localparam int NW      = $clog2(MAX_GRID + 1);
    localparam int CNT_W   = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int AW      = $clog2(2 * MAX_GRID + 1);
    localparam int CW      = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int VDEPTH  = 2 ** AW;
    localparam int CDEPTH  = 2 ** CW;
    localparam int RESET_N = (gsmv_pkg::GRID_RESET > MAX_GRID) ? MAX_GRID
                                                               : gsmv_pkg::GRID_RESET;
    localparam int ULW     = gsmv_pkg::QLW + 1;

    // line buffers
    gsmv_pkg::value_t    value_mem [VDEPTH];
    gsmv_pkg::coef_set_t coef_mem  [CDEPTH];

    logic [NW-1:0]    n_reg, n_next, n_cfg;
    logic [CNT_W-1:0] total_reg, total_next, total_cfg;
    logic [2*NW-1:0]  square;
    logic [CNT_W-1:0] in_count_reg, in_count_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic [NW-1:0]    col_reg, col_next, row_reg, row_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next, p_addr_reg, p_addr_next;
    logic             f1_valid_reg;

    gsmv_pkg::value_t    west_rd_reg, mid_rd_reg, east_rd_reg, south_rd_reg, north_reg;
    gsmv_pkg::value_t    first_reg;
    gsmv_pkg::coef_set_t coef_rd_reg;
    logic                west_ok_reg, east_ok_reg, north_ok_reg, south_ok_reg, last_reg;

    logic             accept, grid_full, take_data, make_job, p_last;
    logic [ULW-1:0]   used;

    // clamp the written size to 1..MAX_GRID
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            n_cfg = NW'(1);
        end
        else if (int'(cfg_wdata) > MAX_GRID)
        begin
            n_cfg = NW'(MAX_GRID);
        end
        else
        begin
            n_cfg = NW'(cfg_wdata);
        end
        square    = (2 * NW)'(n_cfg) * (2 * NW)'(n_cfg);
        total_cfg = CNT_W'(square);
    end

    // room for this word's job plus the one in flight
    assign used       = ULW'(q_status.level) + ULW'(f1_valid_reg);
    assign item_stall = (used >= ULW'(gsmv_pkg::QDEPTH));

    assign accept    = item_valid && !item_stall;
    assign grid_full = (in_count_reg == total_reg);
    assign take_data = accept && (op == gsmv_pkg::OP_DATA) && !grid_full;
    assign make_job  = (take_data && (in_count_reg >= CNT_W'(n_reg)))
                    || (accept && (op == gsmv_pkg::OP_DRAIN) && grid_full
                        && (out_count_reg < total_reg));
    assign p_last    = (out_count_reg == total_reg - CNT_W'(1));

    always_comb
    begin
        n_next         = n_reg;
        total_next     = total_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wr_addr_next   = wr_addr_reg;
        p_addr_next    = p_addr_reg;
        if (cfg_we)
        begin
            n_next         = n_cfg;
            total_next     = total_cfg;
            in_count_next  = '0;
            out_count_next = '0;
            col_next       = '0;
            row_next       = '0;
            wr_addr_next   = '0;
            p_addr_next    = '0;
        end
        else
        begin
            if (take_data)
            begin
                in_count_next = in_count_reg + CNT_W'(1);
                wr_addr_next  = wr_addr_reg + AW'(1);
            end
            if (make_job)
            begin
                if (p_last)
                begin
                    in_count_next  = '0;
                    out_count_next = '0;
                    col_next       = '0;
                    row_next       = '0;
                    wr_addr_next   = '0;
                    p_addr_next    = '0;
                end
                else
                begin
                    out_count_next = out_count_reg + CNT_W'(1);
                    p_addr_next    = p_addr_reg + AW'(1);
                    if (col_reg == n_reg - NW'(1))
                    begin
                        col_next = '0;
                        row_next = row_reg + NW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + NW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= NW'(RESET_N);
            total_reg     <= CNT_W'(RESET_N * RESET_N);
            in_count_reg  <= '0;
            out_count_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            wr_addr_reg   <= '0;
            p_addr_reg    <= '0;
            f1_valid_reg  <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            total_reg     <= total_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            wr_addr_reg   <= wr_addr_next;
            p_addr_reg    <= p_addr_next;
            f1_valid_reg  <= make_job;
        end
    end

    // reads see the old contents when a write hits the same entry
    always_ff @(posedge clk)
    begin
        if (take_data)
        begin
            value_mem[wr_addr_reg]         <= point_value;
            coef_mem[wr_addr_reg[CW-1:0]]  <= '{coef_west, coef_east, coef_north, coef_south};
            // first point of the grid, the west neighbour of the second
            if (in_count_reg == '0)
            begin
                first_reg <= point_value;
            end
        end
        if (make_job)
        begin
            // own value and west neighbour follow the east read of earlier points
            mid_rd_reg   <= (out_count_reg == '0) ? first_reg : east_rd_reg;
            west_rd_reg  <= mid_rd_reg;
            east_rd_reg  <= value_mem[p_addr_reg + AW'(1)];
            south_rd_reg <= value_mem[p_addr_reg - AW'(n_reg)];
            coef_rd_reg  <= coef_mem[p_addr_reg[CW-1:0]];
            north_reg    <= point_value;
            west_ok_reg  <= (col_reg != '0);
            east_ok_reg  <= (col_reg != n_reg - NW'(1));
            north_ok_reg <= (row_reg != n_reg - NW'(1));
            south_ok_reg <= (row_reg != '0);
            last_reg     <= p_last;
        end
    end

    always_comb
    begin
        job_push.valid     = f1_valid_reg;
        job_push.job.west  = west_ok_reg  ? west_rd_reg  : '0;
        job_push.job.east  = east_ok_reg  ? east_rd_reg  : '0;
        job_push.job.north = north_ok_reg ? north_reg    : '0;
        job_push.job.south = south_ok_reg ? south_rd_reg : '0;
        job_push.job.coef  = coef_rd_reg;
        job_push.job.last  = last_reg;
    end

endmodule

FILE: rtl/gsmv_queue.sv
// ----------------------------------------------------------------------------
// gsmv_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module gsmv_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gsmv_pkg::job_push_t     job_push,
    input  logic                    pop,
    output gsmv_pkg::job_t          head,
    output gsmv_pkg::queue_status_t q_status
);

    gsmv_pkg::job_t entry_mem [gsmv_pkg::QDEPTH];

    logic [gsmv_pkg::QPW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [gsmv_pkg::QLW-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (job_push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + gsmv_pkg::QPW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + gsmv_pkg::QPW'(1);
        end
        if (job_push.valid && !pop)
        begin
            level_next = level_reg + gsmv_pkg::QLW'(1);
        end
        else if (!job_push.valid && pop)
        begin
            level_next = level_reg - gsmv_pkg::QLW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_push.valid)
        begin
            entry_mem[wr_ptr_reg] <= job_push.job;
        end
    end

    assign head               = entry_mem[rd_ptr_reg];
    assign q_status.not_empty = (level_reg != '0);
    assign q_status.level     = level_reg;

endmodule

FILE: rtl/gsmv_back.sv
// ----------------------------------------------------------------------------
// gsmv_back
// products, rounded sum and saturation, with the result output register
// ----------------------------------------------------------------------------
module gsmv_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gsmv_pkg::job_t          head,
    input  gsmv_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output gsmv_pkg::value_t        product_value,
    output logic                    saturated,
    output logic                    grid_done
);

    localparam int PW = gsmv_pkg::PROD_W;
    localparam int SW = gsmv_pkg::SUM_W;
    localparam int RW = SW - gsmv_pkg::FRAC_W;
    localparam int VW = gsmv_pkg::VALUE_W;

    logic signed [PW-1:0] prod_w_reg, prod_e_reg, prod_n_reg, prod_s_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 m_valid_reg, m_last_reg, s_valid_reg, s_last_reg;
    logic                 o_valid_reg, o_sat_reg, o_done_reg;
    gsmv_pkg::value_t     o_value_reg;

    logic                 out_free, s_free, m_free;
    logic signed [RW-1:0] rounded;
    logic                 clip_hi, clip_lo;

    assign out_free = !o_valid_reg || !result_stall;
    assign s_free   = !s_valid_reg || out_free;
    assign m_free   = !m_valid_reg || s_free;
    assign pop      = q_status.not_empty && m_free;

    // floor((sum + half) / 2^16) then clip to 32 bits
    assign rounded = sum_reg[SW-1:gsmv_pkg::FRAC_W];
    assign clip_hi = !rounded[RW-1] && (|rounded[RW-2:VW-1]);
    assign clip_lo = rounded[RW-1] && !(&rounded[RW-2:VW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_free)
            begin
                m_valid_reg <= pop;
            end
            if (s_free)
            begin
                s_valid_reg <= m_valid_reg;
            end
            if (out_free)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_w_reg <= PW'(head.coef.west)  * PW'(head.west);
            prod_e_reg <= PW'(head.coef.east)  * PW'(head.east);
            prod_n_reg <= PW'(head.coef.north) * PW'(head.north);
            prod_s_reg <= PW'(head.coef.south) * PW'(head.south);
            m_last_reg <= head.last;
        end
        if (s_free && m_valid_reg)
        begin
            sum_reg    <= SW'(prod_w_reg) + SW'(prod_e_reg) + SW'(prod_n_reg)
                        + SW'(prod_s_reg) + gsmv_pkg::ROUND_BIAS;
            s_last_reg <= m_last_reg;
        end
        if (out_free && s_valid_reg)
        begin
            if (clip_hi)
            begin
                o_value_reg <= {1'b0, {(VW - 1){1'b1}}};
            end
            else if (clip_lo)
            begin
                o_value_reg <= {1'b1, {(VW - 1){1'b0}}};
            end
            else
            begin
                o_value_reg <= rounded[VW-1:0];
            end
            o_sat_reg  <= clip_hi || clip_lo;
            o_done_reg <= s_last_reg;
        end
    end

    assign result_valid  = o_valid_reg;
    assign product_value = o_value_reg;
    assign saturated     = o_sat_reg;
    assign grid_done     = o_done_reg;

endmodule

FILE: rtl/grid_stencil_matvec.sv
// path of a completing word: front job registers, queue, product, sum, output registers
// throughput: one word per cycle while item_stall is low, set by the line buffer reads
// in the front and the fully pipelined multiply, sum and clip stages in the back
// reset: counters cleared, grid size 64 (clamped to MAX_GRID), no memory clearing pass
// ----------------------------------------------------------------------------
// grid_stencil_matvec
// four-point stencil matrix-vector product over a square grid in raster order
// ----------------------------------------------------------------------------
module grid_stencil_matvec #(
    parameter int MAX_GRID = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // size register
    input  logic                       cfg_we,
    input  logic [gsmv_pkg::CFG_W-1:0] cfg_wdata,
    // input words
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       op,
    input  logic signed [31:0]         point_value,
    input  logic signed [17:0]         coef_west,
    input  logic signed [17:0]         coef_east,
    input  logic signed [17:0]         coef_north,
    input  logic signed [17:0]         coef_south,
    // result words
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [31:0]         product_value,
    output logic                       saturated,
    output logic                       grid_done
);

    // front: counts points, writes the value and coefficient line buffers, reads the
    // neighbours of the point one row back and hands a masked job to the queue
    // queue: four entries so front and back stall on their own
    // back: four products, rounded sum, clip, output register

    gsmv_pkg::job_push_t     job_push;
    gsmv_pkg::queue_status_t q_status;
    gsmv_pkg::job_t          head;
    logic                    pop;

    gsmv_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .op          (op),
        .point_value (point_value),
        .coef_west   (coef_west),
        .coef_east   (coef_east),
        .coef_north  (coef_north),
        .coef_south  (coef_south),
        .q_status    (q_status),
        .job_push    (job_push)
    );

    gsmv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    gsmv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .product_value (product_value),
        .saturated     (saturated),
        .grid_done     (grid_done)
    );

    // the credit check must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.level == gsmv_pkg::QLW'(gsmv_pkg::QDEPTH)) |-> !job_push.valid)
        else $error("job queue overflow");

    // a full queue always holds the input off
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.level == gsmv_pkg::QLW'(gsmv_pkg::QDEPTH)) |-> item_stall)
        else $error("input not stalled with full queue");

    // a clipped word carries one of the two range limits
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            ((product_value == 32'sh7fffffff) || (product_value == 32'sh80000000)))
        else $error("saturated word not at a range limit");

endmodule
